// ===== src/etmc_pkg.sv =====
package etmc_pkg;

    // Fixed widths of the stream payloads.
    localparam int RESULT_W   = 14;
    localparam int NUM_W      = 4;
    localparam int ROW_W      = 3;
    localparam int COL_W      = 3;
    localparam int IN_COST_W  = 12;
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 16;

    // Cost that stands for "no tour found yet".
    localparam logic [RESULT_W-1:0] TOUR_CAP = 14'd9999;

    // City count after reset.
    localparam logic [NUM_W-1:0] NUM_RESET = 4'd8;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ONE_RD,
        S_ONE,
        S_LOOP,
        S_POP,
        S_LEAF_A,
        S_LEAF_B
    } srch_state_t;

    typedef enum logic [1:0] {
        T_LOAD,
        T_SEARCH,
        T_HOLD
    } top_state_t;

    typedef struct packed {
        logic start;
        logic one_city;
    } srch_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } srch_stat_t;

endpackage

// ===== src/etmc_ram.sv =====
module etmc_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/etmc_search.sv =====
module etmc_search #(
    parameter int MAX_CITIES = 8,
    parameter int COST_BITS  = 12
) (
    input  logic                                      aclk,
    input  logic                                      aresetn,
    input  etmc_pkg::srch_ctrl_t                      ctrl,
    input  logic [$clog2(MAX_CITIES+1)-1:0]           n,
    output logic [$clog2(MAX_CITIES*MAX_CITIES)-1:0]  rd_addr,
    input  logic [COST_BITS-1:0]                      rd_data,
    output etmc_pkg::srch_stat_t                      stat,
    output logic [etmc_pkg::RESULT_W-1:0]             result
);
    import etmc_pkg::*;

    localparam int CITY_W = $clog2(MAX_CITIES);
    localparam int NC_W   = $clog2(MAX_CITIES + 1);
    localparam int ADDR_W = $clog2(MAX_CITIES * MAX_CITIES);
    localparam int SUM_W  = ((RESULT_W > COST_BITS) ? RESULT_W : COST_BITS) + 1;

    srch_state_t state_reg, state_next;

    logic [CITY_W-1:0]     depth_reg, depth_next;
    logic [MAX_CITIES-1:0] visited_reg, visited_next;
    logic [CITY_W-1:0]     cur_city_reg, cur_city_next;
    logic [NC_W-1:0]       cur_nc_reg, cur_nc_next;
    logic [RESULT_W-1:0]   cur_best_reg, cur_best_next;
    logic [RESULT_W-1:0]   value_reg, value_next;
    logic [CITY_W-1:0]     cand_reg, cand_next;
    logic [COST_BITS-1:0]  edge_a_reg, edge_a_next;

    // Saved context of the levels above the current one.
    logic [CITY_W-1:0]   path_reg [MAX_CITIES];
    logic [NC_W-1:0]     nc_reg   [MAX_CITIES];
    logic [RESULT_W-1:0] best_reg [MAX_CITIES];

    logic              push_en;
    logic [CITY_W-1:0] cand;
    logic [CITY_W-1:0] up;
    logic              exhausted;
    logic              at_root;
    logic              leaf_lvl;
    logic [SUM_W-1:0]  leaf_sum;
    logic [SUM_W-1:0]  pop_sum;

    function automatic logic [ADDR_W-1:0] edge_addr(input logic [CITY_W-1:0] from,
                                                    input logic [CITY_W-1:0] to);
        edge_addr = ADDR_W'(int'(from) * MAX_CITIES + int'(to));
    endfunction

    assign cand      = cur_nc_reg[CITY_W-1:0];
    assign up        = depth_reg - CITY_W'(1);
    assign exhausted = (cur_nc_reg >= n);
    assign at_root   = (depth_reg == CITY_W'(1));
    assign leaf_lvl  = ((NC_W'(depth_reg) + NC_W'(1)) == n);
    assign leaf_sum  = SUM_W'(edge_a_reg) + SUM_W'(rd_data);
    assign pop_sum   = SUM_W'(rd_data) + SUM_W'(value_reg);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (ctrl.start) begin
                    state_next = ctrl.one_city ? S_ONE_RD : S_LOOP;
                end
            end
            // The final entry is written at the start edge, so the read of
            // the city 0 entry is issued in the state after it.
            S_ONE_RD: state_next = S_ONE;
            S_ONE:    state_next = S_IDLE;
            S_LOOP: begin
                if (exhausted) begin
                    state_next = at_root ? S_IDLE : S_POP;
                end else if (!visited_reg[cand] && leaf_lvl) begin
                    state_next = S_LEAF_A;
                end
            end
            S_POP:    state_next = S_LOOP;
            S_LEAF_A: state_next = S_LEAF_B;
            S_LEAF_B: state_next = S_LOOP;
            default:  state_next = S_IDLE;
        endcase
    end

    always_comb begin
        rd_addr   = edge_addr(CITY_W'(0), CITY_W'(0));
        stat.busy = (state_reg != S_IDLE);
        stat.done = 1'b0;
        result    = cur_best_reg;
        unique case (state_reg)
            S_ONE: begin
                stat.done = 1'b1;
                result    = RESULT_W'(rd_data);
            end
            S_LOOP: begin
                if (exhausted) begin
                    rd_addr   = edge_addr(path_reg[up], cur_city_reg);
                    stat.done = at_root;
                end else begin
                    rd_addr = edge_addr(cur_city_reg, cand);
                end
            end
            S_LEAF_A: rd_addr = edge_addr(cand_reg, CITY_W'(0));
            default: ;
        endcase
    end

    always_comb begin
        depth_next    = depth_reg;
        visited_next  = visited_reg;
        cur_city_next = cur_city_reg;
        cur_nc_next   = cur_nc_reg;
        cur_best_next = cur_best_reg;
        value_next    = value_reg;
        cand_next     = cand_reg;
        edge_a_next   = edge_a_reg;
        push_en       = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                if (ctrl.start) begin
                    depth_next    = CITY_W'(1);
                    visited_next  = MAX_CITIES'(1);
                    cur_city_next = '0;
                    cur_nc_next   = '0;
                    cur_best_next = TOUR_CAP;
                end
            end
            S_LOOP: begin
                if (exhausted) begin
                    if (at_root) begin
                        visited_next = '0;
                        depth_next   = '0;
                    end else begin
                        // Back up one level; the edge into this city is being read.
                        visited_next[cur_city_reg] = 1'b0;
                        value_next    = cur_best_reg;
                        cur_city_next = path_reg[up];
                        cur_nc_next   = nc_reg[up];
                        cur_best_next = best_reg[up];
                        depth_next    = up;
                    end
                end else begin
                    cur_nc_next = cur_nc_reg + NC_W'(1);
                    if (!visited_reg[cand]) begin
                        if (leaf_lvl) begin
                            cand_next = cand;
                        end else begin
                            push_en             = 1'b1;
                            visited_next[cand]  = 1'b1;
                            cur_city_next       = cand;
                            cur_nc_next         = '0;
                            cur_best_next       = TOUR_CAP;
                            depth_next          = depth_reg + CITY_W'(1);
                        end
                    end
                end
            end
            S_POP: begin
                if (pop_sum < SUM_W'(cur_best_reg)) begin
                    cur_best_next = RESULT_W'(pop_sum);
                end
            end
            S_LEAF_A: edge_a_next = rd_data;
            S_LEAF_B: begin
                if (leaf_sum < SUM_W'(cur_best_reg)) begin
                    cur_best_next = RESULT_W'(leaf_sum);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            depth_reg   <= '0;
            visited_reg <= '0;
        end else begin
            state_reg   <= state_next;
            depth_reg   <= depth_next;
            visited_reg <= visited_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_city_reg <= cur_city_next;
        cur_nc_reg   <= cur_nc_next;
        cur_best_reg <= cur_best_next;
        value_reg    <= value_next;
        cand_reg     <= cand_next;
        edge_a_reg   <= edge_a_next;
        if (push_en) begin
            path_reg[depth_reg] <= cur_city_reg;
            nc_reg[depth_reg]   <= cur_nc_reg + NC_W'(1);
            best_reg[depth_reg] <= cur_best_reg;
        end
    end

endmodule

// ===== src/exhaustive_tour_min_cost.sv =====
// Exhaustive minimum-cost tour search over a directed cost matrix.
//
// The slave stream carries one matrix entry per transaction: row, column and
// cost in s_tdata, with s_tlast marking the final entry. Every entry is written
// into the matrix memory in the cycle it is accepted; entries outside the built
// matrix are dropped. The transaction with s_tlast set is stored too and then
// starts a depth-first search over every tour that leaves city 0, visits each
// active city once and returns to city 0. The master stream then carries one
// transaction: the cheapest tour cost, limited to 9999, or with a single active
// city the cost of the entry from city 0 to itself.
// Loading accepts one entry per cycle while s_tready is high. The search is one
// sequencer stepping through the candidates over a single memory read port: a
// candidate test or a descent is an S_LOOP step, a return to the level above also
// passes S_POP, and a completed tour also S_LEAF_A and S_LEAF_B. s_tready is low
// while it runs. The finished result sits in an output register until the receiver
// takes it; a stalled master side holds the block after the search only while an
// earlier result is still untaken. The city count register is written over the cfg
// channel while idle, a rule the user keeps and the block does not enforce; it reads
// 8 after reset. Reset is synchronous and active low; the matrix memory is not
// cleared, so every entry the search reads must be written first.
module exhaustive_tour_min_cost #(
    parameter int MAX_CITIES = 8,
    parameter int COST_BITS  = 12
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // Matrix entry transactions.
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [etmc_pkg::IN_DATA_W-1:0]      s_tdata,   // row[2:0], col[5:3], edge_cost[17:6]
    input  logic                                s_tlast,   // last_entry
    // Result transactions.
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [etmc_pkg::OUT_DATA_W-1:0]     m_tdata,   // min_tour_cost[13:0]
    // City count register.
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [etmc_pkg::NUM_W-1:0]          cfg_data   // num_cities
);
    import etmc_pkg::*;

    localparam int NC_W   = $clog2(MAX_CITIES + 1);
    localparam int DEPTH  = MAX_CITIES * MAX_CITIES;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam logic [NUM_W:0] MAX_N = (NUM_W + 1)'(MAX_CITIES);

    top_state_t state_reg, state_next;

    logic [NUM_W-1:0]      num_cities_reg, num_cities_next;
    logic                  m_tvalid_reg, m_tvalid_next;
    logic [RESULT_W-1:0]   m_data_reg, m_data_next;
    logic [RESULT_W-1:0]   result_reg, result_next;

    logic [ROW_W-1:0]      in_row;
    logic [COL_W-1:0]      in_col;
    logic [IN_COST_W-1:0]  in_cost;
    logic                  s_accept;
    logic                  entry_ok;
    logic                  wr_en;
    logic [ADDR_W-1:0]     wr_addr;
    logic [ADDR_W-1:0]     rd_addr;
    logic [COST_BITS-1:0]  rd_data;
    logic [NC_W-1:0]       n_active;
    logic                  out_free;
    logic                  load_out;

    srch_ctrl_t            ctrl;
    srch_stat_t            stat;
    logic [RESULT_W-1:0]   srch_result;

    assign in_row   = s_tdata[ROW_W-1:0];
    assign in_col   = s_tdata[ROW_W+COL_W-1:ROW_W];
    assign in_cost  = s_tdata[ROW_W+COL_W+IN_COST_W-1:ROW_W+COL_W];
    assign s_accept = s_tvalid && s_tready;

    assign entry_ok = ((NUM_W + 1)'(in_row) < MAX_N) && ((NUM_W + 1)'(in_col) < MAX_N);
    assign wr_en    = s_accept && entry_ok;
    assign wr_addr  = ADDR_W'(int'(in_row) * MAX_CITIES + int'(in_col));

    // Zero counts as one city, anything above the built size as the built size.
    always_comb begin
        priority if (num_cities_reg == '0) begin
            n_active = NC_W'(1);
        end else if ((NUM_W + 1)'(num_cities_reg) > MAX_N) begin
            n_active = NC_W'(MAX_CITIES);
        end else begin
            n_active = NC_W'(num_cities_reg);
        end
    end

    assign cfg_ready       = 1'b1;
    assign num_cities_next = (cfg_valid && cfg_ready) ? cfg_data : num_cities_reg;

    assign out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            T_LOAD: begin
                if (s_accept && s_tlast) begin
                    state_next = T_SEARCH;
                end
            end
            T_SEARCH: begin
                if (stat.done) begin
                    state_next = T_HOLD;
                end
            end
            T_HOLD: begin
                if (out_free) begin
                    state_next = T_LOAD;
                end
            end
            default: state_next = T_LOAD;
        endcase
    end

    always_comb begin
        s_tready      = 1'b0;
        ctrl.start    = 1'b0;
        ctrl.one_city = (n_active == NC_W'(1));
        load_out      = 1'b0;
        unique case (state_reg)
            T_LOAD: begin
                s_tready   = 1'b1;
                ctrl.start = s_tvalid && s_tlast;
            end
            T_HOLD:  load_out = out_free;
            default: ;
        endcase
    end

    assign result_next = (state_reg == T_SEARCH && stat.done) ? srch_result : result_reg;

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_data_next   = m_data_reg;
        if (load_out) begin
            m_tvalid_next = 1'b1;
            m_data_next   = result_reg;
        end else if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= T_LOAD;
            num_cities_reg <= NUM_RESET;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg      <= state_next;
            num_cities_reg <= num_cities_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
        result_reg <= result_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = OUT_DATA_W'(m_data_reg);

    etmc_ram #(
        .WIDTH (COST_BITS),
        .DEPTH (DEPTH)
    ) u_cost_ram (
        .aclk  (aclk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (COST_BITS'(in_cost)),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    etmc_search #(
        .MAX_CITIES (MAX_CITIES),
        .COST_BITS  (COST_BITS)
    ) u_search (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (ctrl),
        .n       (n_active),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .stat    (stat),
        .result  (srch_result)
    );

    // The final entry must launch the search in the next cycle.
    a_start_search: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tlast |=> stat.busy)
        else $error("search did not start after the final entry");

    // A finished search is only reported while the controller waits for it.
    a_done_in_search: assert property (@(posedge aclk) disable iff (!aresetn)
        stat.done |-> state_reg == T_SEARCH)
        else $error("search finished outside the search phase");

    // No matrix entry may be taken while the search reads the memory.
    a_no_load_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        stat.busy |-> !s_tready)
        else $error("entry accepted during the search");

    // A new result only appears after the search result was captured.
    a_result_order: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(state_reg == T_HOLD))
        else $error("result presented without a finished search");

endmodule
